@@ rtl/core/swg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// SwiGLU feed-forward package
// Shared types, request codes, register indexes and the sigmoid table.
// ----------------------------------------------------------------------------
package swg_pkg;

	localparam int MAX_MODEL_WIDTH_DEF  = 64;
	localparam int MAX_HIDDEN_WIDTH_DEF = 128;

	localparam int MODEL_WIDTH_W  = 7;
	localparam int HIDDEN_WIDTH_W = 8;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 8;
	localparam int ACC_W          = 40;

	localparam logic [1:0] OP_GATE  = 2'd0;
	localparam logic [1:0] OP_UP    = 2'd1;
	localparam logic [1:0] OP_DOWN  = 2'd2;
	localparam logic [1:0] OP_TOKEN = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_MODEL_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HIDDEN_WIDTH = 2'd1;

	typedef struct packed {
		logic [1:0]          opcode;
		logic [6:0]          row;
		logic [6:0]          col;
		logic signed [15:0]  value;
	} req_t;

	typedef struct packed {
		logic [5:0]          out_index;
		logic signed [15:0]  out_value;
		logic                last;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GU,
		ST_GU_FIN,
		ST_DN,
		ST_DN_FIN,
		ST_OUT
	} state_t;

	typedef logic [16:0] sig_tab_t [256];

	// Restoring division, only ever evaluated while the sigmoid table is elaborated.
	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], a[i]};
			if (r >= {1'b0, b}) begin
				r = r - {1'b0, b};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Sigmoid at the bin midpoints, Q0.16, built from a truncated series for e^(-1/32).
	function automatic sig_tab_t build_sig_table();
		sig_tab_t    tab;
		logic [63:0] t;
		logic [63:0] c;
		logic [63:0] p [256];
		logic [63:0] e;
		logic [63:0] den;
		logic [63:0] num;
		int          m;
		t = 64'd1 << 32;
		c = t;
		for (int n = 1; n <= 8; n++) begin
			t = udiv64(t, 64'd32 * 64'(n));
			if ((n & 1) == 1) c = c - t;
			else c = c + t;
		end
		p[0] = 64'd1 << 32;
		for (int k = 1; k < 256; k++) begin
			if (k == 1) p[k] = c;
			else p[k] = (p[k-1] * c) >> 32;
		end
		for (int k = 0; k < 256; k++) begin
			m = 2 * k - 255;
			e = p[(m < 0) ? -m : m];
			den = (64'd1 << 32) + e;
			num = (m >= 0) ? (64'd1 << 32) : e;
			tab[k] = 17'(udiv64((num << 16) + (den >> 1), den));
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TABLE = build_sig_table();

	// Shift right by eight with rounding (ties upwards), then saturate to Q8.8.
	function automatic logic signed [15:0] rnd8_sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = (v + ACC_W'(128)) >>> 8;
		if (r > ACC_W'(32767)) return 16'sh7fff;
		if (r < -ACC_W'(32768)) return 16'sh8000;
		return r[15:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/swg_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/core/swiglu_feed_forward_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// SwiGLU feed-forward unit
// Q8.8 transformer feed-forward: gate and up projections, SiLU gating, down
// projection, all from on-chip weight memories through one shared MAC path.
// ----------------------------------------------------------------------------
// Weight loads and token elements other than the last are taken one per cycle.
// The last element of a token starts the computation; the unit then stalls
// requests until every result has been taken. Each memory has a single read
// port: the unit reads one token element and one gate and up weight per cycle,
// then one hidden value and one down weight per cycle, pausing while a result
// waits to be taken. Results are offered one at a time from an output register.
module swiglu_feed_forward_unit #(
	parameter int MAX_MODEL_WIDTH  = swg_pkg::MAX_MODEL_WIDTH_DEF,
	parameter int MAX_HIDDEN_WIDTH = swg_pkg::MAX_HIDDEN_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_stall,
	input  wire swg_pkg::req_t                      req,
	output logic                                    res_valid,
	input  wire logic                               res_stall,
	output swg_pkg::rsp_t                           res,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [swg_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [swg_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import swg_pkg::*;

	localparam int MW_IDX_W = (MAX_MODEL_WIDTH > 1) ? $clog2(MAX_MODEL_WIDTH) : 1;
	localparam int HW_IDX_W = (MAX_HIDDEN_WIDTH > 1) ? $clog2(MAX_HIDDEN_WIDTH) : 1;
	localparam int W_DEPTH  = MAX_MODEL_WIDTH * MAX_HIDDEN_WIDTH;
	localparam int W_AW     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
	localparam int MAX_DIM  = (MAX_MODEL_WIDTH > MAX_HIDDEN_WIDTH) ?
		MAX_MODEL_WIDTH : MAX_HIDDEN_WIDTH;
	localparam int CNT_W    = $clog2(MAX_DIM + 1);

	// Configuration registers.
	logic [MODEL_WIDTH_W-1:0]  model_width_q;
	logic [HIDDEN_WIDTH_W-1:0] hidden_width_q;
	logic [7:0]                mw_eff;
	logic [7:0]                hw_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_width_q  <= MODEL_WIDTH_W'(MAX_MODEL_WIDTH);
			hidden_width_q <= HIDDEN_WIDTH_W'(MAX_HIDDEN_WIDTH);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODEL_WIDTH:  model_width_q  <= cfg_data[MODEL_WIDTH_W-1:0];
				REG_HIDDEN_WIDTH: hidden_width_q <= cfg_data[HIDDEN_WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (model_width_q == '0) mw_eff = 8'd1;
		else if ({1'b0, model_width_q} > 8'(MAX_MODEL_WIDTH)) mw_eff = 8'(MAX_MODEL_WIDTH);
		else mw_eff = {1'b0, model_width_q};
		if (hidden_width_q == '0) hw_eff = 8'd1;
		else if (hidden_width_q > 8'(MAX_HIDDEN_WIDTH)) hw_eff = 8'(MAX_HIDDEN_WIDTH);
		else hw_eff = hidden_width_q;
	end

	// Request decode.
	logic   req_acc;
	logic   row_in_mw, row_in_hw, col_in_mw, col_in_hw;
	logic   tok_last;
	state_t state_q, state_d;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign row_in_mw = {1'b0, req.row} < mw_eff;
	assign row_in_hw = {1'b0, req.row} < hw_eff;
	assign col_in_mw = {1'b0, req.col} < mw_eff;
	assign col_in_hw = {1'b0, req.col} < hw_eff;
	assign tok_last  = req_acc && (req.opcode == OP_TOKEN) && row_in_mw &&
		({1'b0, req.row} == mw_eff - 8'd1);

	// Sequencer registers.
	logic [7:0]          mw_run_q, hw_run_q;
	logic [HW_IDX_W-1:0] h_q;
	logic [MW_IDX_W-1:0] j_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [1:0]          fin_q;
	logic                v_s1, v_s2;
	logic                issue, drained, cnt_done, h_last, j_last, acc_clr;
	logic [7:0]          lim;

	assign lim      = (state_q == ST_GU) ? mw_run_q : hw_run_q;
	assign cnt_done = (8'(cnt_q) == lim);
	assign drained  = !v_s1 && !v_s2;
	assign issue    = ((state_q == ST_GU) || (state_q == ST_DN)) && !cnt_done;
	assign h_last   = (8'(h_q) == hw_run_q - 8'd1);
	assign j_last   = (8'(j_q) == mw_run_q - 8'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tok_last) state_d = ST_GU;
			end
			ST_GU: begin
				if (cnt_done && drained) state_d = ST_GU_FIN;
			end
			ST_GU_FIN: begin
				if (fin_q == 2'd3) state_d = h_last ? ST_DN : ST_GU;
			end
			ST_DN: begin
				if (cnt_done && drained) state_d = ST_DN_FIN;
			end
			ST_DN_FIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!res_stall) state_d = j_last ? ST_IDLE : ST_DN;
			end
			default: state_d = ST_IDLE;
		endcase
		acc_clr = (state_d != state_q) && ((state_d == ST_GU) || (state_d == ST_DN));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mw_run_q <= '0;
			hw_run_q <= '0;
			h_q      <= '0;
			j_q      <= '0;
			cnt_q    <= '0;
			fin_q    <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (state_q == ST_IDLE && tok_last) begin
				mw_run_q <= mw_eff;
				hw_run_q <= hw_eff;
				h_q      <= '0;
				j_q      <= '0;
				cnt_q    <= '0;
				fin_q    <= '0;
			end
			if (issue) cnt_q <= cnt_q + CNT_W'(1);
			if (state_q == ST_GU_FIN) begin
				fin_q <= fin_q + 2'd1;
				if (fin_q == 2'd3) begin
					cnt_q <= '0;
					h_q   <= h_last ? '0 : h_q + HW_IDX_W'(1);
				end
			end
			if (state_q == ST_OUT && !res_stall && !j_last) begin
				j_q   <= j_q + MW_IDX_W'(1);
				cnt_q <= '0;
			end
		end
	end

	// Memories.
	logic                     tok_we, gate_we, up_we, down_we, hid_we;
	logic [MW_IDX_W-1:0]      tok_raddr;
	logic [HW_IDX_W-1:0]      hid_raddr;
	logic [W_AW-1:0]          wt_waddr, down_waddr, gu_raddr, down_raddr;
	logic signed [15:0]       tok_rd, gate_rd, up_rd, down_rd, hid_rd, hid_wdata;

	assign tok_we     = req_acc && (req.opcode == OP_TOKEN) && row_in_mw;
	assign gate_we    = req_acc && (req.opcode == OP_GATE) && row_in_mw && col_in_hw;
	assign up_we      = req_acc && (req.opcode == OP_UP) && row_in_mw && col_in_hw;
	assign down_we    = req_acc && (req.opcode == OP_DOWN) && row_in_hw && col_in_mw;
	assign wt_waddr   = W_AW'(int'(req.row) * MAX_HIDDEN_WIDTH + int'(req.col));
	assign down_waddr = W_AW'(int'(req.row) * MAX_MODEL_WIDTH + int'(req.col));
	assign tok_raddr  = MW_IDX_W'(cnt_q);
	assign hid_raddr  = HW_IDX_W'(cnt_q);
	assign gu_raddr   = W_AW'(int'(cnt_q) * MAX_HIDDEN_WIDTH + int'(h_q));
	assign down_raddr = W_AW'(int'(cnt_q) * MAX_MODEL_WIDTH + int'(j_q));
	assign hid_we     = (state_q == ST_GU_FIN) && (fin_q == 2'd3);

	swg_ram #(.WIDTH(16), .DEPTH(MAX_MODEL_WIDTH)) u_tok_ram (
		.clk(clk), .we(tok_we), .waddr(MW_IDX_W'(req.row)), .wdata(req.value),
		.raddr(tok_raddr), .rdata(tok_rd)
	);
	swg_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_gate_ram (
		.clk(clk), .we(gate_we), .waddr(wt_waddr), .wdata(req.value),
		.raddr(gu_raddr), .rdata(gate_rd)
	);
	swg_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_up_ram (
		.clk(clk), .we(up_we), .waddr(wt_waddr), .wdata(req.value),
		.raddr(gu_raddr), .rdata(up_rd)
	);
	swg_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_down_ram (
		.clk(clk), .we(down_we), .waddr(down_waddr), .wdata(req.value),
		.raddr(down_raddr), .rdata(down_rd)
	);
	swg_ram #(.WIDTH(16), .DEPTH(MAX_HIDDEN_WIDTH)) u_hid_ram (
		.clk(clk), .we(hid_we), .waddr(h_q), .wdata(hid_wdata),
		.raddr(hid_raddr), .rdata(hid_rd)
	);

	// MAC path: read data, product register, accumulate.
	logic signed [15:0]      mul_a, mul_b;
	logic signed [31:0]      prod_a_s2, prod_u_s2;
	logic signed [ACC_W-1:0] acc_a_q, acc_u_q;

	assign mul_a = (state_q == ST_GU) ? tok_rd : hid_rd;
	assign mul_b = (state_q == ST_GU) ? gate_rd : down_rd;

	always_ff @(posedge clk) begin
		prod_a_s2 <= mul_a * mul_b;
		prod_u_s2 <= tok_rd * up_rd;
		if (acc_clr) begin
			acc_a_q <= '0;
			acc_u_q <= '0;
		end else if (v_s2) begin
			acc_a_q <= acc_a_q + ACC_W'(prod_a_s2);
			acc_u_q <= acc_u_q + ACC_W'(prod_u_s2);
		end
	end

	// Hidden value: saturate, sigmoid lookup, SiLU, gating product.
	logic signed [15:0] g_q, u_q;
	logic signed [33:0] gs_q, su_q, gs_rnd;
	logic [16:0]        sig;
	logic [15:0]        g_off;

	assign g_off  = 16'(g_q + 16'sd2048);
	assign gs_rnd = (gs_q + 34'sd32768) >>> 16;

	always_comb begin
		if (g_q < -16'sd2048) sig = '0;
		else if (g_q >= 16'sd2048) sig = 17'd65536;
		else sig = SIG_TABLE[g_off[11:4]];
	end

	assign hid_wdata = rnd8_sat(ACC_W'(su_q));

	always_ff @(posedge clk) begin
		if (state_q == ST_GU_FIN) begin
			unique case (fin_q)
				2'd0: begin
					g_q <= rnd8_sat(acc_a_q);
					u_q <= rnd8_sat(acc_u_q);
				end
				2'd1: gs_q <= g_q * $signed({1'b0, sig});
				2'd2: su_q <= $signed(gs_rnd[17:0]) * u_q;
				2'd3: ;
			endcase
		end
	end

	// Result register.
	rsp_t res_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_DN_FIN) begin
			res_q.out_index <= 6'(j_q);
			res_q.out_value <= rnd8_sat(acc_a_q);
			res_q.last      <= j_last;
		end
	end

	assign res_valid = (state_q == ST_OUT);
	assign res       = res_q;

	// The final result of a token carries the last position of that token.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |-> (8'(res.out_index) == mw_run_q - 8'd1))
		else $error("last flag on wrong output position");

	// Requests are held off for as long as a result is on offer.
	a_stall_on_out: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> req_stall)
		else $error("request accepted while a result is pending");

	// The MAC pipeline only carries data in the two accumulation phases.
	a_pipe_phase: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == ST_GU || state_q == ST_DN))
		else $error("MAC pipeline busy outside an accumulation phase");

	// The hidden index steps only when a hidden value is written.
	a_h_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) && !$stable(h_q) |-> $past(hid_we))
		else $error("hidden index moved without a write");

endmodule
`default_nettype wire

@@ test/swiglu_feed_forward_unit_test.sv @@
// ----------------------------------------------------------------------------
// SwiGLU feed-forward unit testbench
// Loads weight matrices and token elements under a range of width settings,
// predicts every output element in fixed point and checks each result in order
// while both channels idle and stall at random, except in the final phase.
// ----------------------------------------------------------------------------
module swiglu_feed_forward_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import swg_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;
	localparam int MW_MAX = 64;
	localparam int HW_MAX = 128;

	class swiglu_scoreboard;
		longint unsigned sig_q16 [256];
		int              model_reg;
		int              hidden_reg;
		shortint         token_mem [MW_MAX];
		shortint         gate_mem [MW_MAX*HW_MAX];
		shortint         up_mem [MW_MAX*HW_MAX];
		shortint         down_mem [MW_MAX*HW_MAX];
		shortint         hidden_mem [HW_MAX];
		bit              token_set [MW_MAX];
		bit              gate_set [MW_MAX*HW_MAX];
		bit              up_set [MW_MAX*HW_MAX];
		bit              down_set [MW_MAX*HW_MAX];
		rsp_t            pending [$];
		int              errors;

		function new();
			longint unsigned t, c, e, den, num;
			longint unsigned p [256];
			int m;
			t = 64'd1 << 32;
			c = t;
			for (int n = 1; n <= 8; n++) begin
				t = t / (32 * n);
				if (n % 2 == 1) c = c - t;
				else c = c + t;
			end
			p[0] = 64'd1 << 32;
			p[1] = c;
			for (int k = 2; k < 256; k++) p[k] = (p[k-1] * c) >> 32;
			for (int k = 0; k < 256; k++) begin
				m = 2 * k - 255;
				e = p[(m < 0) ? -m : m];
				den = (64'd1 << 32) + e;
				num = (m >= 0) ? (64'd1 << 32) : e;
				sig_q16[k] = ((num << 16) + den / 2) / den;
			end
			model_reg = MW_MAX;
			hidden_reg = HW_MAX;
			errors = 0;
		endfunction

		function int model_dim();
			if (model_reg == 0) return 1;
			return (model_reg > MW_MAX) ? MW_MAX : model_reg;
		endfunction

		function int hidden_dim();
			if (hidden_reg == 0) return 1;
			return (hidden_reg > HW_MAX) ? HW_MAX : hidden_reg;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_MODEL_WIDTH) model_reg = data & 8'h7f;
			else if (idx == REG_HIDDEN_WIDTH) hidden_reg = data;
		endfunction

		// Rounds to nearest with ties upwards: an arithmetic shift is a floor.
		function longint round_shift(longint v, int sh);
			return (v + (longint'(1) << (sh - 1))) >>> sh;
		endfunction

		function longint sat16(longint v);
			if (v > 32767) return 32767;
			if (v < -32768) return -32768;
			return v;
		endfunction

		function void note_request(req_t r);
			int mw, hw;
			mw = model_dim();
			hw = hidden_dim();
			case (r.opcode)
				OP_GATE, OP_UP: begin
					if (r.row < mw && r.col < hw) begin
						if (r.opcode == OP_GATE) begin
							gate_mem[r.row*HW_MAX + r.col] = r.value;
							gate_set[r.row*HW_MAX + r.col] = 1;
						end else begin
							up_mem[r.row*HW_MAX + r.col] = r.value;
							up_set[r.row*HW_MAX + r.col] = 1;
						end
					end
				end
				OP_DOWN: begin
					if (r.row < hw && r.col < mw) begin
						down_mem[r.row*MW_MAX + r.col] = r.value;
						down_set[r.row*MW_MAX + r.col] = 1;
					end
				end
				default: begin
					if (r.row < mw) begin
						token_mem[r.row] = r.value;
						token_set[r.row] = 1;
						if (r.row == mw - 1) compute_token(mw, hw);
					end
				end
			endcase
		endfunction

		function void compute_token(int mw, int hw);
			longint ga, ua, g, u, s, silu, acc;
			rsp_t    rsp;
			for (int h = 0; h < hw; h++) begin
				ga = 0;
				ua = 0;
				for (int i = 0; i < mw; i++) begin
					ga += longint'(token_mem[i]) * gate_mem[i*HW_MAX + h];
					ua += longint'(token_mem[i]) * up_mem[i*HW_MAX + h];
				end
				g = sat16(round_shift(ga, 8));
				u = sat16(round_shift(ua, 8));
				if (g < -2048) s = 0;
				else if (g >= 2048) s = 65536;
				else s = sig_q16[(g + 2048) >> 4];
				silu = round_shift(g * s, 16);
				hidden_mem[h] = shortint'(sat16(round_shift(silu * u, 8)));
			end
			for (int j = 0; j < mw; j++) begin
				acc = 0;
				for (int h = 0; h < hw; h++)
					acc += longint'(hidden_mem[h]) * down_mem[h*MW_MAX + j];
				rsp.out_index = j[5:0];
				rsp.out_value = 16'(sat16(round_shift(acc, 8)));
				rsp.last = (j == mw - 1);
				pending.push_back(rsp);
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
				return;
			end
			want = pending.pop_front();
			if (got.out_index !== want.out_index || got.out_value !== want.out_value ||
			    got.last !== want.last) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected index %0d value %0d last %0b, got %0d %0d %0b",
						want.out_index, want.out_value, want.last,
						got.out_index, got.out_value, got.last);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   req_valid;
	logic                   req_stall;
	req_t                   req;
	logic                   res_valid;
	logic                   res_stall;
	rsp_t                   res;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	swiglu_scoreboard sb = new();
	int send_idle_pct;
	int recv_idle_pct;

	swiglu_feed_forward_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) sb.check_result(res);
		res_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	function automatic req_t make_req(logic [1:0] op, int row, int col, shortint val);
		req_t r;
		r.opcode = op;
		r.row = row[6:0];
		r.col = col[6:0];
		r.value = val;
		return r;
	endfunction

	function automatic shortint rand_q88();
		case ($urandom_range(9))
			0: return -32768;
			1: return 32767;
			2, 3: return shortint'($urandom);
			default: return shortint'(int'($urandom_range(1023)) - 512);
		endcase
	endfunction

	task automatic send_request(req_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	// Waits for all results and lets the unit settle before a register write.
	task automatic configure(int mw, int hw, bit spare);
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		write_reg(REG_MODEL_WIDTH, mw[7:0]);
		write_reg(REG_HIDDEN_WIDTH, hw[7:0]);
		if (spare) begin
			write_reg(REG_SPARE_LO, 8'($urandom));
			write_reg(REG_SPARE_HI, 8'($urandom));
		end
		cfg_valid <= 1'b0;
	endtask

	// Loads every weight and leading token element that the current widths read and that is not yet written.
	task automatic fill_unwritten();
		int mw, hw;
		mw = sb.model_dim();
		hw = sb.hidden_dim();
		for (int i = 0; i < mw; i++)
			for (int h = 0; h < hw; h++) begin
				if (!sb.gate_set[i*HW_MAX + h]) send_request(make_req(OP_GATE, i, h, rand_q88()));
				if (!sb.up_set[i*HW_MAX + h]) send_request(make_req(OP_UP, i, h, rand_q88()));
				if (!sb.down_set[h*MW_MAX + i])
					send_request(make_req(OP_DOWN, h, i, rand_q88()));
			end
		for (int i = 0; i < mw - 1; i++)
			if (!sb.token_set[i]) send_request(make_req(OP_TOKEN, i, 0, rand_q88()));
	endtask

	task automatic random_requests(int count);
		int mw, hw, kind, n;
		mw = sb.model_dim();
		hw = sb.hidden_dim();
		n = 0;
		while (n < count) begin
			kind = $urandom_range(99);
			if (kind < 40)
				send_request(make_req(OP_TOKEN, $urandom_range(mw - 1), $urandom, rand_q88()));
			else if (kind < 55)
				send_request(make_req(OP_TOKEN, mw - 1, $urandom, rand_q88()));
			else if (kind < 85)
				case ($urandom_range(2))
					0: send_request(make_req(OP_GATE, $urandom_range(mw - 1),
						$urandom_range(hw - 1), rand_q88()));
					1: send_request(make_req(OP_UP, $urandom_range(mw - 1),
						$urandom_range(hw - 1), rand_q88()));
					default: send_request(make_req(OP_DOWN, $urandom_range(hw - 1),
						$urandom_range(mw - 1), rand_q88()));
				endcase
			else
				send_request(req_t'($urandom));
			n++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 29;
		recv_idle_pct = 63;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero widths act as one. With unit gate weight the token value is the
		// gate, which walks the sigmoid table edges.
		configure(0, 0, 1'b0);
		send_request(make_req(OP_GATE, 0, 0, 256));
		send_request(make_req(OP_UP, 0, 0, 32767));
		send_request(make_req(OP_DOWN, 0, 0, 32767));
		send_request(make_req(OP_TOKEN, 0, 0, 32767));
		send_request(make_req(OP_TOKEN, 0, 0, -32768));
		send_request(make_req(OP_TOKEN, 0, 127, -2049));
		send_request(make_req(OP_TOKEN, 0, 0, -2048));
		send_request(make_req(OP_TOKEN, 0, 0, 2047));
		send_request(make_req(OP_TOKEN, 0, 0, 2048));
		send_request(make_req(OP_TOKEN, 0, 0, 0));
		send_request(make_req(OP_TOKEN, 0, 0, -1));
		send_request(make_req(OP_GATE, 1, 0, 100));
		send_request(make_req(OP_UP, 0, 1, 100));
		send_request(make_req(OP_DOWN, 1, 0, 100));
		send_request(make_req(OP_DOWN, 0, 127, 100));
		send_request(make_req(OP_TOKEN, 1, 0, 100));
		send_request(make_req(OP_TOKEN, 127, 127, 100));
		send_request(make_req(OP_GATE, 0, 0, -32768));
		send_request(make_req(OP_UP, 0, 0, -32768));
		send_request(make_req(OP_DOWN, 0, 0, -32768));
		send_request(make_req(OP_TOKEN, 0, 0, 32767));
		send_request(make_req(OP_TOKEN, 0, 0, 300));

		// Over-range model width clamps to the maximum.
		configure(200, 1, 1'b1);
		fill_unwritten();
		send_request(make_req(OP_TOKEN, MW_MAX - 1, 0, rand_q88()));
		random_requests(8);

		send_idle_pct = 63;
		recv_idle_pct = 29;
		for (int ph = 0; ph < 3; ph++) begin
			configure($urandom_range(1, 3), $urandom_range(1, 4), ph == 1);
			if (ph == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			fill_unwritten();
			send_request(make_req(OP_TOKEN, sb.model_dim() - 1, 0, rand_q88()));
			random_requests(8);
		end

		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
